[hw/rtl/fdv_pkg.sv]
package fdv_pkg;

    localparam int ROWS = 800;
    localparam int COLS = 1280;

    localparam int ROW_W = 10;
    localparam int COL_W = 11;
    localparam int CODE_W = 8;
    localparam int CNT_W = 20;
    localparam int DIR_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_BINS = 4;

    // frame bounds compared at a width that holds any legal frame size
    localparam int DIM_W = 13;
    localparam logic [DIM_W-1:0] ROWS_LIM = DIM_W'(ROWS);
    localparam logic [DIM_W-1:0] COLS_LIM = DIM_W'(COLS);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // code ranges of the direction bins
    localparam logic [CODE_W-1:0] CODE_RIGHT_MAX = 8'd32;
    localparam logic [CODE_W-1:0] CODE_DOWN_MAX = 8'd96;
    localparam logic [CODE_W-1:0] CODE_LEFT_MAX = 8'd159;
    localparam logic [CODE_W-1:0] CODE_UP_MAX = 8'd223;

    localparam logic [ROW_W-1:0] RST_ROW_FIRST = 10'd0;
    localparam logic [ROW_W-1:0] RST_ROW_FINAL = 10'd799;
    localparam logic [COL_W-1:0] RST_COL_FIRST = 11'd0;
    localparam logic [COL_W-1:0] RST_COL_FINAL = 11'd1279;
    localparam logic [CNT_W-1:0] RST_THRESHOLD = 20'd5000;

    typedef enum logic [1:0] {
        BIN_RIGHT = 2'd0,
        BIN_DOWN  = 2'd1,
        BIN_LEFT  = 2'd2,
        BIN_UP    = 2'd3
    } t_bin;

    typedef enum logic [DIR_W-1:0] {
        DIR_NONE  = 3'd0,
        DIR_LEFT  = 3'd1,
        DIR_RIGHT = 3'd2,
        DIR_UP    = 3'd3,
        DIR_DOWN  = 3'd4
    } t_dir;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_FIRST = 3'd0,
        CFG_ROW_FINAL = 3'd1,
        CFG_COL_FIRST = 3'd2,
        CFG_COL_FINAL = 3'd3,
        CFG_THRESHOLD = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CODE_W-1:0] flow_code;
        logic [ROW_W-1:0]  pixel_row;
        logic [COL_W-1:0]  pixel_col;
        logic              frame_end;
    } t_in;

    typedef struct packed {
        logic [DIR_W-1:0] direction;
        logic [CNT_W-1:0] active_count;
        logic             slip_flag;
    } t_out;

endpackage

[hw/rtl/flow_direction_vote.sv]
// a frame-end item's result passes the snapshot, pair and output registers in turn
// throughput: one item per cycle; frame-end items flow through a 3-deep
// result pipeline, and the input stalls only when a frame-end item meets a full one
// reset: synchronous active low; clears all bin counters and pipeline valids and
// loads the region bounds and threshold with their defaults
module flow_direction_vote (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  fdv_pkg::t_in                        i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output fdv_pkg::t_out                       o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fdv_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fdv_pkg::CNT_W-1:0]           i_cfg_data
);

    // configuration
    logic [fdv_pkg::ROW_W-1:0] r_row_first;
    logic [fdv_pkg::ROW_W-1:0] r_row_final;
    logic [fdv_pkg::COL_W-1:0] r_col_first;
    logic [fdv_pkg::COL_W-1:0] r_col_final;
    logic [fdv_pkg::CNT_W-1:0] r_threshold;

    // input stage
    logic         r_a_valid;
    fdv_pkg::t_in r_a;

    // bin counters
    logic [fdv_pkg::CNT_W-1:0] r_cnt [fdv_pkg::NUM_BINS];
    logic [fdv_pkg::CNT_W-1:0] n_cnt [fdv_pkg::NUM_BINS];
    logic [fdv_pkg::CNT_W-1:0] cnt_upd [fdv_pkg::NUM_BINS];

    // snapshot stage
    logic                      r_c_valid;
    logic [fdv_pkg::CNT_W-1:0] r_c_cnt [fdv_pkg::NUM_BINS];

    // pairwise stage
    logic                        r_d_valid;
    logic [fdv_pkg::DIR_W-1:0]   r_d_dir1;
    logic [fdv_pkg::DIR_W-1:0]   r_d_dir2;
    logic [fdv_pkg::CNT_W-1:0]   r_d_max1;
    logic [fdv_pkg::CNT_W-1:0]   r_d_max2;
    logic [fdv_pkg::CNT_W:0]     r_d_sum1;
    logic [fdv_pkg::CNT_W:0]     r_d_sum2;
    logic [fdv_pkg::DIR_W-1:0]   n_d_dir1;
    logic [fdv_pkg::DIR_W-1:0]   n_d_dir2;
    logic [fdv_pkg::CNT_W-1:0]   n_d_max1;
    logic [fdv_pkg::CNT_W-1:0]   n_d_max2;

    // output stage
    logic          r_out_valid;
    fdv_pkg::t_out r_out;
    fdv_pkg::t_out n_out;

    logic out_free, d_adv, d_free, c_adv, c_free, a_go, a_free, a_last;
    logic in_roi;
    logic [fdv_pkg::NUM_BINS-1:0] hit;
    logic [fdv_pkg::CNT_W+1:0]    total;
    logic [fdv_pkg::DIR_W-1:0]    dir_sel;

    // handshake chain, back to front
    assign out_free = !r_out_valid || i_out_ready;
    assign d_adv    = r_d_valid && out_free;
    assign d_free   = !r_d_valid || d_adv;
    assign c_adv    = r_c_valid && d_free;
    assign c_free   = !r_c_valid || c_adv;
    assign a_go     = r_a_valid && (!r_a.frame_end || c_free);
    assign a_last   = a_go && r_a.frame_end;
    assign a_free   = !r_a_valid || a_go;

    assign o_in_ready  = a_free;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // region test and binning
    always_comb begin
        in_roi = (fdv_pkg::DIM_W'(r_a.pixel_row) < fdv_pkg::ROWS_LIM)
              && (fdv_pkg::DIM_W'(r_a.pixel_col) < fdv_pkg::COLS_LIM)
              && (r_a.pixel_row >= r_row_first) && (r_a.pixel_row <= r_row_final)
              && (r_a.pixel_col >= r_col_first) && (r_a.pixel_col <= r_col_final);
        hit = '0;
        if (in_roi && r_a.flow_code != '0) begin
            priority if (r_a.flow_code <= fdv_pkg::CODE_RIGHT_MAX
                         || r_a.flow_code > fdv_pkg::CODE_UP_MAX) begin
                hit[fdv_pkg::BIN_RIGHT] = 1'b1;
            end else if (r_a.flow_code <= fdv_pkg::CODE_DOWN_MAX) begin
                hit[fdv_pkg::BIN_DOWN] = 1'b1;
            end else if (r_a.flow_code <= fdv_pkg::CODE_LEFT_MAX) begin
                hit[fdv_pkg::BIN_LEFT] = 1'b1;
            end else begin
                hit[fdv_pkg::BIN_UP] = 1'b1;
            end
        end
    end

    // saturating counter lanes
    always_comb begin
        for (int b = 0; b < fdv_pkg::NUM_BINS; b++) begin
            if (hit[b] && r_cnt[b] != fdv_pkg::CNT_MAX) begin
                cnt_upd[b] = r_cnt[b] + 1'b1;
            end else begin
                cnt_upd[b] = r_cnt[b];
            end
            if (a_last) begin
                n_cnt[b] = '0;
            end else if (a_go) begin
                n_cnt[b] = cnt_upd[b];
            end else begin
                n_cnt[b] = r_cnt[b];
            end
        end
    end

    // pairwise winners, ties to the second of each pair
    always_comb begin
        if (r_c_cnt[fdv_pkg::BIN_RIGHT] > r_c_cnt[fdv_pkg::BIN_DOWN]) begin
            n_d_dir1 = fdv_pkg::DIR_RIGHT;
            n_d_max1 = r_c_cnt[fdv_pkg::BIN_RIGHT];
        end else begin
            n_d_dir1 = fdv_pkg::DIR_DOWN;
            n_d_max1 = r_c_cnt[fdv_pkg::BIN_DOWN];
        end
        if (r_c_cnt[fdv_pkg::BIN_LEFT] > r_c_cnt[fdv_pkg::BIN_UP]) begin
            n_d_dir2 = fdv_pkg::DIR_LEFT;
            n_d_max2 = r_c_cnt[fdv_pkg::BIN_LEFT];
        end else begin
            n_d_dir2 = fdv_pkg::DIR_UP;
            n_d_max2 = r_c_cnt[fdv_pkg::BIN_UP];
        end
    end

    // final vote and saturating total
    always_comb begin
        if (r_d_max1 > r_d_max2) begin
            dir_sel = (r_d_max1 > r_threshold) ? r_d_dir1 : fdv_pkg::DIR_NONE;
        end else begin
            dir_sel = (r_d_max2 > r_threshold) ? r_d_dir2 : fdv_pkg::DIR_NONE;
        end
        total = {1'b0, r_d_sum1} + {1'b0, r_d_sum2};
        n_out.direction = dir_sel;
        n_out.active_count = (total > (fdv_pkg::CNT_W+2)'(fdv_pkg::CNT_MAX))
                           ? fdv_pkg::CNT_MAX : total[fdv_pkg::CNT_W-1:0];
        n_out.slip_flag = (dir_sel == fdv_pkg::DIR_UP);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_first <= fdv_pkg::RST_ROW_FIRST;
            r_row_final <= fdv_pkg::RST_ROW_FINAL;
            r_col_first <= fdv_pkg::RST_COL_FIRST;
            r_col_final <= fdv_pkg::RST_COL_FINAL;
            r_threshold <= fdv_pkg::RST_THRESHOLD;
            r_a_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int b = 0; b < fdv_pkg::NUM_BINS; b++) begin
                r_cnt[b] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    fdv_pkg::CFG_ROW_FIRST: r_row_first <= i_cfg_data[fdv_pkg::ROW_W-1:0];
                    fdv_pkg::CFG_ROW_FINAL: r_row_final <= i_cfg_data[fdv_pkg::ROW_W-1:0];
                    fdv_pkg::CFG_COL_FIRST: r_col_first <= i_cfg_data[fdv_pkg::COL_W-1:0];
                    fdv_pkg::CFG_COL_FINAL: r_col_final <= i_cfg_data[fdv_pkg::COL_W-1:0];
                    fdv_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data;
                    default: ;
                endcase
            end
            if (a_free) begin
                r_a_valid <= i_in_valid;
            end
            if (a_last) begin
                r_c_valid <= 1'b1;
            end else if (c_adv) begin
                r_c_valid <= 1'b0;
            end
            if (c_adv) begin
                r_d_valid <= 1'b1;
            end else if (d_adv) begin
                r_d_valid <= 1'b0;
            end
            if (d_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            for (int b = 0; b < fdv_pkg::NUM_BINS; b++) begin
                r_cnt[b] <= n_cnt[b];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (a_free && i_in_valid) begin
            r_a <= i_in_data;
        end
        if (a_last) begin
            for (int b = 0; b < fdv_pkg::NUM_BINS; b++) begin
                r_c_cnt[b] <= cnt_upd[b];
            end
        end
        if (c_adv) begin
            r_d_dir1 <= n_d_dir1;
            r_d_dir2 <= n_d_dir2;
            r_d_max1 <= n_d_max1;
            r_d_max2 <= n_d_max2;
            r_d_sum1 <= {1'b0, r_c_cnt[fdv_pkg::BIN_RIGHT]}
                      + {1'b0, r_c_cnt[fdv_pkg::BIN_DOWN]};
            r_d_sum2 <= {1'b0, r_c_cnt[fdv_pkg::BIN_LEFT]}
                      + {1'b0, r_c_cnt[fdv_pkg::BIN_UP]};
        end
        if (d_adv) begin
            r_out <= n_out;
        end
    end

    // counters start the next frame from zero
    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_last |=> (r_cnt[0] == '0 && r_cnt[1] == '0 && r_cnt[2] == '0 && r_cnt[3] == '0))
        else $error("bin counters not cleared after frame end");

    // input only stalls on a frame-end item waiting for the result pipeline
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_a_valid && r_a.frame_end && r_c_valid))
        else $error("input stalled without a pending frame-end item");

    a_slip_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.slip_flag == (o_out_data.direction == fdv_pkg::DIR_UP)))
        else $error("slip flag disagrees with direction");

    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.direction <= fdv_pkg::DIR_DOWN))
        else $error("direction code out of range");

    // a result leaves the pair stage only into a free output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_out_data))
        else $error("pending item overwritten");

endmodule
